// File: sv/wfp_pkg.sv
// package: widths, register indexes, step kinds and speed helpers for the steering block
package wfp_pkg;

	localparam int DIST_W  = 12;
	localparam int SPEED_W = 7;
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 13;
	localparam int SUM_W   = 16;
	localparam int DIFF_W  = 14;
	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + SUM_W;
	localparam int PROD_D_W = GAIN_W + DIFF_W;
	localparam int ACC_W   = 34;
	localparam int PID_W   = 16;
	localparam int VEL_W   = 18;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CRUISE     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_TURN_ENTER = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_TURN_EXIT  = 3'd6;

	// register reset values
	localparam logic [DIST_W-1:0]  SETPOINT_RST   = 12'd2000;
	localparam logic [SPEED_W-1:0] CRUISE_RST     = 7'd50;
	localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 16'd256;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 16'd0;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 16'd0;
	localparam logic [DIST_W-1:0]  TURN_ENTER_RST = 12'd2900;
	localparam logic [DIST_W-1:0]  TURN_EXIT_RST  = 12'd1000;

	localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
	localparam logic [SPEED_W-1:0] SPEED_FLOOR = 7'd1;

	localparam logic signed [PID_W-1:0] PID_MAX = 16'sh7FFF;
	localparam logic signed [PID_W-1:0] PID_MIN = 16'sh8000;

	// what kind of tick a word is
	typedef enum logic [1:0] {
		STEP_STOP,
		STEP_TURN,
		STEP_PID
	} step_t;

	typedef struct packed {
		step_t step;
		logic  turn_left_fwd;
	} step_ctl_t;

	// wheel speed clamp: negative gives the floor, above the maximum gives the maximum
	function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [VEL_W-1:0] v);
		logic [SPEED_W-1:0] r;
		if (v < 0) begin
			r = SPEED_FLOOR;
		end else if (v > $signed({{(VEL_W-SPEED_W){1'b0}}, SPEED_MAX})) begin
			r = SPEED_MAX;
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: sv/wfp_if.sv
// interfaces: sample, command and configuration channels
interface wfp_sample_if;
	logic                        valid;
	logic                        ready;
	logic [wfp_pkg::DIST_W-1:0]  front_distance;
	logic [wfp_pkg::DIST_W-1:0]  right_distance;
	logic                        emergency_stop;

	modport source (output valid, front_distance, right_distance, emergency_stop, input ready);
	modport sink   (input valid, front_distance, right_distance, emergency_stop, output ready);
endinterface

interface wfp_command_if;
	logic                        valid;
	logic                        ready;
	logic [wfp_pkg::SPEED_W-1:0] left_speed;
	logic [wfp_pkg::SPEED_W-1:0] right_speed;
	logic                        left_forward;
	logic                        right_forward;
	logic                        motors_enabled;

	modport source (output valid, left_speed, right_speed, left_forward, right_forward,
		motors_enabled, input ready);
	modport sink   (input valid, left_speed, right_speed, left_forward, right_forward,
		motors_enabled, output ready);
endinterface

interface wfp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wfp_pkg::CFG_ADDR_W-1:0] addr;
	logic [wfp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// File: sv/wall_follow_pid_steering_top.sv
// top level: wall-following steering controller with PID and left-turn handling
//
// Channels: sample (sink) carries one control tick per word: front and right
// distance samples and the emergency-stop flag. command (source) returns one
// wheel command word per tick. cfg (sink) writes the seven setup registers by
// index; it is always ready and should only be written while no tick is in flight.
// Pipeline: a sample word's error terms are registered at acceptance, then the product,
// sum/saturate and speed stages each register it before it appears on command.
// Throughput: one sample word per cycle unless stalled; the turn flag and, on PID ticks,
// error sum and previous error update when a non-stop word is taken; the next can follow.
// Stalls: each stage holds its word while the stage after it is full; sample.ready
// stays high while any stage has a bubble, so a word waiting on command does not
// stop new words entering until the pipeline is full.
// Reset: arst_n clears the pipeline, the controller state and loads the register
// defaults (setpoint 2000, cruise 50, Kp 1.0, Ki 0, Kd 0, enter 2900, exit 1000).
module wall_follow_pid_steering_top (
	input  logic              clk,
	input  logic              arst_n,
	wfp_cfg_if.sink           cfg,
	wfp_sample_if.sink        sample,
	wfp_command_if.source     command
);

	// configuration registers
	logic [wfp_pkg::DIST_W-1:0]         setpoint_q;
	logic [wfp_pkg::SPEED_W-1:0]        cruise_q;
	logic signed [wfp_pkg::GAIN_W-1:0]  gain_p_q;
	logic signed [wfp_pkg::GAIN_W-1:0]  gain_i_q;
	logic signed [wfp_pkg::GAIN_W-1:0]  gain_d_q;
	logic [wfp_pkg::DIST_W-1:0]         turn_enter_q;
	logic [wfp_pkg::DIST_W-1:0]         turn_exit_q;

	// controller state
	logic                               turning_q;
	logic signed [wfp_pkg::SUM_W-1:0]   err_sum_q;
	logic signed [wfp_pkg::ERR_W-1:0]   prev_err_q;

	// pipeline
	logic                               valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                               load_s1, load_s2, load_s3, load_out;
	wfp_pkg::step_ctl_t                 ctl_s1, ctl_s2, ctl_s3;
	logic signed [wfp_pkg::ERR_W-1:0]   err_s1;
	logic signed [wfp_pkg::SUM_W-1:0]   sum_s1;
	logic signed [wfp_pkg::DIFF_W-1:0]  diff_s1;
	logic signed [wfp_pkg::PROD_P_W-1:0] prod_p_s2;
	logic signed [wfp_pkg::PROD_I_W-1:0] prod_i_s2;
	logic signed [wfp_pkg::PROD_D_W-1:0] prod_d_s2;
	logic signed [wfp_pkg::PID_W-1:0]   pid_s3;

	// output registers
	logic [wfp_pkg::SPEED_W-1:0]        left_speed_q, right_speed_q;
	logic                               left_fwd_q, right_fwd_q, motors_en_q;

	// combinational
	logic                               sample_acc;
	wfp_pkg::step_ctl_t                 ctl_in;
	logic signed [wfp_pkg::ERR_W-1:0]   err_in;
	logic signed [wfp_pkg::SUM_W-1:0]   sum_in;
	logic signed [wfp_pkg::DIFF_W-1:0]  diff_in;
	logic signed [wfp_pkg::PROD_P_W-1:0] prod_p;
	logic signed [wfp_pkg::PROD_I_W-1:0] prod_i;
	logic signed [wfp_pkg::PROD_D_W-1:0] prod_d;
	logic signed [wfp_pkg::ACC_W-1:0]   acc;
	logic signed [wfp_pkg::ACC_W-9:0]   acc_div;
	logic signed [wfp_pkg::PID_W-1:0]   pid_sat;
	logic signed [wfp_pkg::VEL_W-1:0]   vel_right, vel_left, cruise_ext, pid_ext;
	logic [wfp_pkg::SPEED_W-1:0]        turn_speed;
	logic [wfp_pkg::SPEED_W-1:0]        left_speed_d, right_speed_d;
	logic                               left_fwd_d, right_fwd_d, motors_en_d;

	// handshake: each stage loads when empty or when its word moves on
	assign load_out     = !out_valid_q || command.ready;
	assign load_s3      = !valid_s3 || load_out;
	assign load_s2      = !valid_s2 || load_s3;
	assign load_s1      = !valid_s1 || load_s2;
	assign sample.ready = load_s1;
	assign sample_acc   = sample.valid && sample.ready;
	assign cfg.ready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= wfp_pkg::SETPOINT_RST;
			cruise_q     <= wfp_pkg::CRUISE_RST;
			gain_p_q     <= wfp_pkg::GAIN_P_RST;
			gain_i_q     <= wfp_pkg::GAIN_I_RST;
			gain_d_q     <= wfp_pkg::GAIN_D_RST;
			turn_enter_q <= wfp_pkg::TURN_ENTER_RST;
			turn_exit_q  <= wfp_pkg::TURN_EXIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				wfp_pkg::REG_SETPOINT:   setpoint_q   <= cfg.data[wfp_pkg::DIST_W-1:0];
				wfp_pkg::REG_CRUISE:     cruise_q     <= cfg.data[wfp_pkg::SPEED_W-1:0];
				wfp_pkg::REG_GAIN_P:     gain_p_q     <= cfg.data;
				wfp_pkg::REG_GAIN_I:     gain_i_q     <= cfg.data;
				wfp_pkg::REG_GAIN_D:     gain_d_q     <= cfg.data;
				wfp_pkg::REG_TURN_ENTER: turn_enter_q <= cfg.data[wfp_pkg::DIST_W-1:0];
				wfp_pkg::REG_TURN_EXIT:  turn_exit_q  <= cfg.data[wfp_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// error terms and tick kind at acceptance
	always_comb begin
		err_in  = $signed({1'b0, setpoint_q}) - $signed({1'b0, sample.right_distance});
		sum_in  = err_sum_q + {{(wfp_pkg::SUM_W-wfp_pkg::ERR_W){err_in[wfp_pkg::ERR_W-1]}},
			err_in};
		diff_in = {err_in[wfp_pkg::ERR_W-1], err_in} - {prev_err_q[wfp_pkg::ERR_W-1], prev_err_q};
		ctl_in.turn_left_fwd = 1'b0;
		if (sample.emergency_stop) begin
			ctl_in.step = wfp_pkg::STEP_STOP;
		end else if (turning_q) begin
			ctl_in.step = wfp_pkg::STEP_TURN;
			ctl_in.turn_left_fwd = sample.front_distance < turn_exit_q;
		end else begin
			ctl_in.step = wfp_pkg::STEP_PID;
		end
	end

	// controller state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turning_q  <= 1'b0;
			err_sum_q  <= '0;
			prev_err_q <= '0;
		end else if (sample_acc && !sample.emergency_stop) begin
			if (turning_q) begin
				if (sample.front_distance < turn_exit_q) begin
					turning_q <= 1'b0;
				end
			end else begin
				if (sample.front_distance > turn_enter_q) begin
					turning_q <= 1'b1;
				end
				err_sum_q  <= sum_in;
				prev_err_q <= err_in;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= sample.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
			if (load_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// stage 1: captured error terms
	always_ff @(posedge clk) begin
		if (load_s1) begin
			ctl_s1  <= ctl_in;
			err_s1  <= err_in;
			sum_s1  <= sum_in;
			diff_s1 <= diff_in;
		end
	end

	// stage 2: gain products
	assign prod_p = gain_p_q * err_s1;
	assign prod_i = gain_i_q * sum_s1;
	assign prod_d = gain_d_q * diff_s1;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			ctl_s2    <= ctl_s1;
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_d_s2 <= prod_d;
		end
	end

	// stage 3: sum, drop fraction toward zero, saturate
	always_comb begin
		acc = {{(wfp_pkg::ACC_W-wfp_pkg::PROD_P_W){prod_p_s2[wfp_pkg::PROD_P_W-1]}}, prod_p_s2}
			+ {{(wfp_pkg::ACC_W-wfp_pkg::PROD_I_W){prod_i_s2[wfp_pkg::PROD_I_W-1]}}, prod_i_s2}
			+ {{(wfp_pkg::ACC_W-wfp_pkg::PROD_D_W){prod_d_s2[wfp_pkg::PROD_D_W-1]}}, prod_d_s2};
		acc_div = acc[wfp_pkg::ACC_W-1:8];
		if (acc[wfp_pkg::ACC_W-1] && (acc[7:0] != 8'd0)) begin
			acc_div = acc_div + 26'sd1;
		end
		if (acc_div > $signed({{(wfp_pkg::ACC_W-8-wfp_pkg::PID_W){1'b0}}, wfp_pkg::PID_MAX})) begin
			pid_sat = wfp_pkg::PID_MAX;
		end else if (acc_div < $signed({{(wfp_pkg::ACC_W-8-wfp_pkg::PID_W){1'b1}},
			wfp_pkg::PID_MIN})) begin
			pid_sat = wfp_pkg::PID_MIN;
		end else begin
			pid_sat = acc_div[wfp_pkg::PID_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			ctl_s3 <= ctl_s2;
			pid_s3 <= pid_sat;
		end
	end

	// output stage: wheel speeds and directions
	always_comb begin
		cruise_ext = $signed({{(wfp_pkg::VEL_W-wfp_pkg::SPEED_W){1'b0}}, cruise_q});
		pid_ext    = {{(wfp_pkg::VEL_W-wfp_pkg::PID_W){pid_s3[wfp_pkg::PID_W-1]}}, pid_s3};
		vel_right  = cruise_ext - pid_ext;
		vel_left   = cruise_ext + pid_ext;
		turn_speed = (cruise_q > wfp_pkg::SPEED_MAX) ? wfp_pkg::SPEED_MAX : cruise_q;
		case (ctl_s3.step)
			wfp_pkg::STEP_TURN: begin
				left_speed_d  = turn_speed;
				right_speed_d = turn_speed;
				left_fwd_d    = ctl_s3.turn_left_fwd;
				right_fwd_d   = 1'b1;
				motors_en_d   = 1'b1;
			end
			wfp_pkg::STEP_PID: begin
				left_speed_d  = wfp_pkg::clamp_speed(vel_left);
				right_speed_d = wfp_pkg::clamp_speed(vel_right);
				left_fwd_d    = 1'b1;
				right_fwd_d   = 1'b1;
				motors_en_d   = 1'b1;
			end
			default: begin
				left_speed_d  = '0;
				right_speed_d = '0;
				left_fwd_d    = 1'b0;
				right_fwd_d   = 1'b0;
				motors_en_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_speed_q  <= left_speed_d;
			right_speed_q <= right_speed_d;
			left_fwd_q    <= left_fwd_d;
			right_fwd_q   <= right_fwd_d;
			motors_en_q   <= motors_en_d;
		end
	end

	// command channel
	assign command.valid          = out_valid_q;
	assign command.left_speed     = left_speed_q;
	assign command.right_speed    = right_speed_q;
	assign command.left_forward   = left_fwd_q;
	assign command.right_forward  = right_fwd_q;
	assign command.motors_enabled = motors_en_q;

endmodule
